// ===== rtl/cdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int WORD_W    = 32;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [WORD_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  rear_value;
    logic                      is_empty;
    logic                      is_full;
  } out_word_t;

  // result flags handed from the controller to the output stage
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    is_empty;
    logic    is_full;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/cdq_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_mem
// Slot store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cdq_mem import cdq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic [IW-1:0]     rd_a_addr,
  input  wire logic [IW-1:0]     rd_b_addr,
  output      logic [WORD_W-1:0] rd_a_data,
  output      logic [WORD_W-1:0] rd_b_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// Command sequencer: head/tail pointers, empty flag, slot writes, status.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; #(
  parameter int IW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clr,
  input  wire logic [CAP_W-1:0]  cap,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire in_word_t          in_data,
  output      res_t              res,
  input  wire logic              out_free,
  output      logic              wr_en,
  output      logic [IW-1:0]     wr_addr,
  output      logic [WORD_W-1:0] wr_data,
  output      logic [IW-1:0]     rd_head,
  output      logic [IW-1:0]     rd_tail
);

  localparam int XW = ((IW > CAP_W) ? IW : CAP_W) + 1;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i,
                                              input logic [CAP_W-1:0] c);
    logic [XW-1:0] s;
    s = XW'(i) + XW'(1);
    return (s >= XW'(c)) ? '0 : IW'(s);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i,
                                              input logic [CAP_W-1:0] c);
    logic [XW-1:0] s;
    s = (i == '0) ? (XW'(c) - XW'(1)) : (XW'(i) - XW'(1));
    return IW'(s);
  endfunction

  state_t         state, state_next;
  logic [IW-1:0]  head, head_next;
  logic [IW-1:0]  tail, tail_next;
  logic           empty, empty_next;
  status_t        status, status_next;
  logic           accept;
  logic           is_push;
  logic           full_now;

  assign accept   = in_valid && in_ready;
  assign is_push  = (in_data.cmd == CMD_PUSH_BACK) || (in_data.cmd == CMD_PUSH_FRONT);
  assign full_now = !empty && (ring_next(tail, cap) == head);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = S_RESP;
      S_RESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready     = (state == S_IDLE);
    res.valid    = (state == S_RESP);
    res.status   = status;
    res.is_empty = empty;
    res.is_full  = full_now;
  end

  // pointer update and slot write for an accepted command
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = in_data.value;
    if (is_push) begin
      priority if (full_now) begin
        status_next = ST_OVERFLOW;
      end else if (empty) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
        wr_en      = accept;
        wr_addr    = '0;
      end else if (in_data.cmd == CMD_PUSH_BACK) begin
        tail_next = ring_next(tail, cap);
        wr_en     = accept;
        wr_addr   = tail_next;
      end else begin
        head_next = ring_prev(head, cap);
        wr_en     = accept;
        wr_addr   = head_next;
      end
    end else begin
      priority if (empty) begin
        status_next = ST_UNDERFLOW;
      end else if (head == tail) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (in_data.cmd == CMD_POP_FRONT) begin
        head_next = ring_next(head, cap);
      end else begin
        tail_next = ring_prev(tail, cap);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      empty  <= 1'b1;
      status <= ST_DONE;
    end else begin
      state <= state_next;
      if (clr) begin
        head  <= '0;
        tail  <= '0;
        empty <= 1'b1;
      end else if (accept) begin
        head   <= head_next;
        tail   <= tail_next;
        empty  <= empty_next;
        status <= status_next;
      end
    end
  end

  assign rd_head = head;
  assign rd_tail = tail;

endmodule
`default_nettype wire

// ===== rtl/circular_deque_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_core
// Circular double-ended queue of signed 32-bit words held in a slot memory.
// ----------------------------------------------------------------------------
//  port group   direction  handshake          word
//  in_*         input      in_valid/in_ready  in_word_t  (cmd, value)
//  out_*        output     out_valid/out_ready out_word_t (status, ends, flags)
//  cfg_*        input      cfg_we, no wait    capacity, 5 bits
//
//  A command runs in three steps: accept (pointer update and slot write),
//  slot read of head and tail, then load of the output register.
//  The slot read step is needed because both slot memory read ports are registered.
//  A held output word stalls the sequencer in its response step only.
//  Reset empties the deque and sets capacity to 16 (limited to DEPTH and to 31);
//  a capacity write also empties the deque.
// ----------------------------------------------------------------------------
module circular_deque_core import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire in_word_t         in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      out_word_t        out_data,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

  function automatic logic [CAP_W-1:0] cap_limit(input logic [CAP_W-1:0] raw);
    logic [CAP_W-1:0] c;
    c = raw;
    if (raw == '0) begin
      c = CAP_W'(1);
    end else if (int'(raw) > CAP_MAX) begin
      c = CAP_W'(CAP_MAX);
    end
    return c;
  endfunction

  logic [CAP_W-1:0]  cap;
  res_t              res;
  logic              out_free;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [IW-1:0]     rd_head;
  logic [IW-1:0]     rd_tail;
  logic [WORD_W-1:0] head_data;
  logic [WORD_W-1:0] tail_data;

  // capacity register, kept already limited
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= cap_limit(CAP_W'(CAP_RESET));
    end else if (cfg_we) begin
      cap <= cap_limit(cfg_wdata);
    end
  end

  cdq_ctrl #(.IW(IW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .clr      (cfg_we),
    .cap      (cap),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res      (res),
    .out_free (out_free),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_head  (rd_head),
    .rd_tail  (rd_tail)
  );

  cdq_mem #(.DEPTH(DEPTH), .IW(IW)) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_head),
    .rd_b_addr (rd_tail),
    .rd_a_data (head_data),
    .rd_b_data (tail_data)
  );

  assign out_free = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_data.status      <= res.status;
      out_data.front_value <= res.is_empty ? EMPTY_WORD : $signed(head_data);
      out_data.rear_value  <= res.is_empty ? EMPTY_WORD : $signed(tail_data);
      out_data.is_empty    <= res.is_empty;
      out_data.is_full     <= res.is_full;
    end
  end

  // checks
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while another is in flight");

  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("deque reported both empty and full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_UNDERFLOW) |-> out_data.is_empty)
    else $error("underflow reported on a non-empty deque");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_OVERFLOW) |-> out_data.is_full)
    else $error("overflow reported on a deque that is not full");

endmodule
`default_nettype wire

// ===== tb/sv/tb_circular_deque_core.sv =====
// ----------------------------------------------------------------------------
// tb_circular_deque_core
// Self-checking bench for the circular deque: a directed opening covers
// underflow, first pushes at either end, extreme words, overflow and the
// small capacities, then phases of random fill and drain traffic at
// several capacities. A local deque model predicts every result word and
// the monitor compares it field by field, in order, under random idling
// on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_circular_deque_core;
  import cdq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 40;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // stimulus and expected result words
  in_word_t  cmd_backlog[$];
  out_word_t ends_expected[$];

  // local deque model
  logic signed [WORD_W-1:0] ring [DEPTH];
  int                       head_pos  = 0;
  int                       tail_pos  = 0;
  bit                       dq_empty  = 1'b1;
  logic [CAP_W-1:0]         dq_cap    = CAP_W'(CAP_RESET);

  // run control and bookkeeping
  bit idle_on      = 1'b1;
  int holds_asked  = 0;
  int holds_served = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int errors       = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_overflow   = 0;
  int n_underflow  = 0;
  int n_full       = 0;
  int n_cap_writes = 0;

  circular_deque_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring index helpers
  function automatic int step_fwd(int i, int c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int step_back(int i, int c);
    return (i == 0) ? c - 1 : i - 1;
  endfunction

  function automatic bit ring_full(int c);
    return !dq_empty && step_fwd(tail_pos, c) == head_pos;
  endfunction

  // advance the model by one command and return the word it should report
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int c;
    c = (dq_cap == 0) ? 1 : ((int'(dq_cap) > DEPTH) ? DEPTH : int'(dq_cap));
    r.status = ST_DONE;
    if (w.cmd == CMD_PUSH_BACK || w.cmd == CMD_PUSH_FRONT) begin
      if (ring_full(c)) begin
        r.status = ST_OVERFLOW;
      end else if (dq_empty) begin
        // first word lands in slot 0 whatever the end
        head_pos = 0;
        tail_pos = 0;
        dq_empty = 1'b0;
        ring[0]  = w.value;
      end else if (w.cmd == CMD_PUSH_BACK) begin
        tail_pos       = step_fwd(tail_pos, c);
        ring[tail_pos] = w.value;
      end else begin
        head_pos       = step_back(head_pos, c);
        ring[head_pos] = w.value;
      end
    end else begin
      if (dq_empty) begin
        r.status = ST_UNDERFLOW;
      end else if (head_pos == tail_pos) begin
        head_pos = 0;
        tail_pos = 0;
        dq_empty = 1'b1;
      end else if (w.cmd == CMD_POP_FRONT) begin
        head_pos = step_fwd(head_pos, c);
      end else begin
        tail_pos = step_back(tail_pos, c);
      end
    end
    r.front_value = dq_empty ? EMPTY_WORD : ring[head_pos];
    r.rear_value  = dq_empty ? EMPTY_WORD : ring[tail_pos];
    r.is_empty    = dq_empty;
    r.is_full     = ring_full(c);
    if (r.status == ST_OVERFLOW) n_overflow++;
    if (r.status == ST_UNDERFLOW) n_underflow++;
    if (r.is_full) n_full++;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d (0x%h), got %0d (0x%h)", $time, field,
               $signed(want), want, $signed(got), got);
    end
  endfunction

  // driver: next word from the backlog, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_backlog.size() > 0) begin
        in_data  <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check delivered words, then predict for accepted ones
  always @(posedge clk) begin : monitor_proc
    out_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (ends_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got %p", $time, out_data);
        end else begin
          want = ends_expected.pop_front();
          n_checked++;
          check_field("status", want.status, out_data.status);
          check_field("front_value", want.front_value, out_data.front_value);
          check_field("rear_value", want.rear_value, out_data.rear_value);
          check_field("is_empty", want.is_empty, out_data.is_empty);
          check_field("is_full", want.is_full, out_data.is_full);
        end
      end
      if (in_valid && in_ready) begin
        n_accepted++;
        ends_expected.push_back(apply_command(in_data));
      end
    end
  end

  task automatic queue_cmd(cmd_t c, logic signed [WORD_W-1:0] v);
    in_word_t w;
    w.cmd   = c;
    w.value = v;
    cmd_backlog.push_back(w);
  endtask

  // wait until every queued word is through and its result checked
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || ends_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    // a capacity write also empties the deque
    dq_cap   = v;
    head_pos = 0;
    tail_pos = 0;
    dq_empty = 1'b1;
    n_cap_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    unique case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // fill-biased start, drain-biased end
  task automatic random_phase(int fill_pct);
    int pct;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      pct = (k < 24) ? fill_pct : 25;
      if ($urandom_range(0, 99) < pct)
        queue_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
      else
        queue_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_word());
    end
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset capacity: underflow, first push at the front, extreme words
    queue_cmd(CMD_POP_FRONT, 32'sd3);
    queue_cmd(CMD_POP_BACK, -32'sd3);
    queue_cmd(CMD_PUSH_FRONT, 32'sd11);
    queue_cmd(CMD_PUSH_BACK, 32'sh7fffffff);
    queue_cmd(CMD_PUSH_FRONT, 32'sh80000000);
    queue_cmd(CMD_PUSH_BACK, -32'sd1);
    queue_cmd(CMD_PUSH_FRONT, 32'sd0);
    queue_cmd(CMD_POP_FRONT, 32'sd0);
    queue_cmd(CMD_POP_BACK, 32'sd0);
    queue_cmd(CMD_POP_FRONT, 32'sd0);
    queue_cmd(CMD_POP_BACK, 32'sd0);
    queue_cmd(CMD_POP_FRONT, 32'sd0);
    queue_cmd(CMD_POP_BACK, 32'sd0);

    // single slot: full after one push, overflow at both ends
    set_capacity(5'd1);
    queue_cmd(CMD_PUSH_BACK, 32'sd5);
    queue_cmd(CMD_PUSH_FRONT, 32'sd6);
    queue_cmd(CMD_PUSH_BACK, 32'sd7);
    queue_cmd(CMD_POP_BACK, 32'sd0);
    queue_cmd(CMD_PUSH_FRONT, 32'sd9);
    queue_cmd(CMD_POP_FRONT, 32'sd0);

    // zero capacity acts as one; the deque is left holding a word
    set_capacity(5'd0);
    queue_cmd(CMD_PUSH_FRONT, -32'sd77);
    queue_cmd(CMD_PUSH_BACK, 32'sd78);

    // oversized capacity saturates, with a long output hold-off
    set_capacity(5'd31);
    holds_asked++;
    random_phase(90);

    set_capacity(5'd2);
    random_phase(60);
    set_capacity(5'd16);
    random_phase(85);
    // same value again, written over a non-empty deque
    set_capacity(5'd16);
    random_phase(80);
    set_capacity(5'd3);
    random_phase(55);
    set_capacity(5'd5);
    random_phase(70);
    set_capacity(5'd17);
    random_phase(85);
    set_capacity(5'd8);
    random_phase(65);
    set_capacity(5'd1);
    random_phase(50);

    // last stretch at full rate, no idling
    set_capacity(5'($urandom_range(0, 31)));
    idle_on = 1'b0;
    random_phase(75);
    drain();

    $display("covered %0d commands and %0d result words over %0d capacity writes",
             n_accepted, n_checked, n_cap_writes);
    $display("saw %0d overflows, %0d underflows and %0d full results",
             n_overflow, n_underflow, n_full);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cdq_pkg.sv
rtl/cdq_mem.sv
rtl/cdq_ctrl.sv
rtl/circular_deque_core.sv
tb/sv/tb_circular_deque_core.sv
